/* rtl/wta_pkg.sv */
// shared types and status codes for the window time average block
package wta_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EARLY    = 2'd1;
    localparam logic [1:0] ST_LATE     = 2'd2;
    localparam logic [1:0] ST_REVERSED = 2'd3;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [31:0] sample_value;
        logic        last_sample;
    } in_word_t;

    typedef struct packed {
        logic [31:0] average;
        logic [1:0]  status;
    } out_word_t;

endpackage

/* rtl/window_time_average.sv */
// window time average: clipped trapezoid area over a sample series, divided by window length
// a sample may only update state, or may need two interpolations, an area step and the final average.
// each interpolation and the average go through one shared 64/32 restoring divider,
// one quotient bit per cycle, then a finishing step; one 32x32 multiplier feeds it.
// one sample at a time: in_stall is high while a sample is being worked.
// rst_n (async, low) clears window registers and pass state.
module window_time_average
    import wta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_PT_MUL, S_PT_DIV, S_LA_MUL, S_LA_DIV, S_LB_MUL, S_LB_DIV,
        S_AR_MUL, S_AR_ADD, S_AV_DIV, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] ws_reg, we_reg;
    in_word_t    in_reg, in_next;
    logic [31:0] pt_reg, pt_next, pv_reg, pv_next;
    logic        have_reg, have_next, fin_reg, fin_next;
    logic [63:0] area_reg, area_next;
    logic [31:0] va_reg, va_next, vb_reg, vb_next;
    logic [63:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] ravg_reg, ravg_next;
    logic [1:0]  rst_reg, rst_next;
    logic        ov_reg, ov_next;
    out_word_t   ow_reg, ow_next;

    logic [31:0] t, v, a, b, diff, mul_a, mul_b, lerp_val, d;
    logic        up, last;
    logic [32:0] rem_sh, vsum;
    logic        ge;
    logic [63:0] seg;
    logic [64:0] asum;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? we_reg : ws_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= '0;
            we_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                we_reg <= pwdata;
            else
                ws_reg <= pwdata;
        end
    end

    assign t    = in_reg.sample_time;
    assign v    = in_reg.sample_value;
    assign last = in_reg.last_sample;
    assign a    = (pt_reg > ws_reg) ? pt_reg : ws_reg;
    assign b    = (t < we_reg) ? t : we_reg;
    assign d    = b - a;
    assign up   = (v >= pv_reg);
    assign diff = up ? (v - pv_reg) : (pv_reg - v);
    assign lerp_val = up ? (pv_reg + q_reg[31:0]) : (pv_reg - q_reg[31:0]);
    assign vsum = {1'b0, va_reg} + {1'b0, vb_reg};
    assign seg  = q_reg + (vsum[0] ? {33'd0, d[31:1]} : 64'd0);
    assign asum = {1'b0, area_reg} + {1'b0, seg};

    // restoring divider step
    assign rem_sh = {rem_reg[31:0], q_reg[63]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        case (state_reg)
            S_PT_MUL: mul_b = ws_reg - pt_reg;
            S_LA_MUL: mul_b = a - pt_reg;
            S_LB_MUL: mul_b = b - pt_reg;
            default:  mul_b = vsum[32:1];
        endcase
        mul_a = (state_reg == S_AR_MUL) ? d : diff;
    end

    always_comb
    begin
        state_next = state_reg;
        in_next    = in_reg;
        pt_next    = pt_reg;
        pv_next    = pv_reg;
        have_next  = have_reg;
        fin_next   = fin_reg;
        area_next  = area_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        ravg_next  = ravg_reg;
        rst_next   = rst_reg;
        ov_next    = ov_reg;
        ow_next    = ow_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_word;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ravg_next = '0;
                if (fin_reg)
                begin
                    if (last)
                    begin
                        pt_next = '0; pv_next = '0; have_next = 1'b0;
                        area_next = '0; fin_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else if (ws_reg > we_reg)
                begin
                    rst_next = ST_REVERSED;
                    state_next = S_OUT;
                end
                else if (!have_reg)
                begin
                    if (t > ws_reg)
                    begin
                        rst_next = ST_EARLY;
                        state_next = S_OUT;
                    end
                    else if (t == ws_reg && ws_reg == we_reg)
                    begin
                        rst_next = ST_OK;
                        ravg_next = v;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pt_next = t; pv_next = v; have_next = 1'b1;
                        rst_next = ST_LATE;
                        state_next = last ? S_OUT : S_IDLE;
                    end
                end
                else if (t > pt_reg)
                begin
                    if (ws_reg == we_reg)
                    begin
                        if (t >= ws_reg)
                            state_next = S_PT_MUL;
                        else
                        begin
                            pt_next = t; pv_next = v;
                            rst_next = ST_LATE;
                            state_next = last ? S_OUT : S_IDLE;
                        end
                    end
                    else if (a < b)
                        state_next = S_LA_MUL;
                    else
                        state_next = S_AR_ADD;
                end
                else
                begin
                    rst_next = ST_LATE;
                    state_next = last ? S_OUT : S_IDLE;
                end
            end
            S_PT_MUL, S_LA_MUL, S_LB_MUL, S_AR_MUL:
            begin
                q_next   = mul_a * mul_b;
                rem_next = '0;
                dvs_next = t - pt_reg;
                cnt_next = 7'd64;
                case (state_reg)
                    S_PT_MUL: state_next = S_PT_DIV;
                    S_LA_MUL: state_next = S_LA_DIV;
                    S_LB_MUL: state_next = S_LB_DIV;
                    default:  state_next = S_AR_ADD;
                endcase
            end
            S_PT_DIV, S_LA_DIV, S_LB_DIV, S_AV_DIV:
            begin
                rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                q_next   = {q_reg[62:0], ge};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    rem_next = rem_reg;
                    q_next   = q_reg;
                    case (state_reg)
                        S_PT_DIV:
                        begin
                            ravg_next = lerp_val;
                            rst_next = ST_OK;
                            state_next = S_OUT;
                        end
                        S_LA_DIV:
                        begin
                            va_next = lerp_val;
                            state_next = S_LB_MUL;
                        end
                        S_LB_DIV:
                        begin
                            vb_next = lerp_val;
                            state_next = S_AR_MUL;
                        end
                        default:
                        begin
                            ravg_next = (q_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : q_reg[31:0];
                            rst_next = ST_OK;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_AR_ADD:
            begin
                // entered with a >= b too: then no area is added
                if (a < b)
                    area_next = asum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : asum[63:0];
                if (t >= we_reg)
                begin
                    q_next   = (a < b) ? area_next : area_reg;
                    rem_next = '0;
                    dvs_next = we_reg - ws_reg;
                    cnt_next = 7'd64;
                    state_next = S_AV_DIV;
                end
                else
                begin
                    pt_next = t; pv_next = v;
                    rst_next = ST_LATE;
                    state_next = last ? S_OUT : S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ow_next.status  = rst_reg;
                    ow_next.average = (rst_reg == ST_OK) ? ravg_reg : 32'd0;
                    if (last)
                    begin
                        pt_next = '0; pv_next = '0; have_next = 1'b0;
                        area_next = '0; fin_next = 1'b0;
                    end
                    else
                        fin_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pt_reg    <= '0;
            pv_reg    <= '0;
            have_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            area_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            pv_reg    <= pv_next;
            have_reg  <= have_next;
            fin_reg   <= fin_next;
            area_reg  <= area_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        va_reg   <= va_next;
        vb_reg   <= vb_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        ravg_reg <= ravg_next;
        rst_reg  <= rst_next;
        ow_reg   <= ow_next;
    end

endmodule

/* tb/sv/tb_window_time_average.sv */
// testbench for the window time average block: directed and random sample series
module tb_window_time_average;
    import wta_pkg::*;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_END   = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;

    // predictor state
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [31:0] last_time;
    logic [31:0] last_value;
    logic        seen_first;
    logic [63:0] area_acc;
    logic        pass_done;

    out_word_t   averages_due[$];
    int          errors;
    logic        sender_idle;

    window_time_average dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic [31:0] interp(input logic [31:0] t0, input logic [31:0] v0,
                                           input logic [31:0] t1, input logic [31:0] v1,
                                           input logic [31:0] x);
        logic [63:0] span;
        logic [63:0] off;
        logic [63:0] delta;
        span = {32'd0, t1} - {32'd0, t0};
        off = {32'd0, x} - {32'd0, t0};
        if (v1 >= v0)
        begin
            delta = ({32'd0, v1 - v0} * off) / span;
            return v0 + delta[31:0];
        end
        delta = ({32'd0, v0 - v1} * off) / span;
        return v0 - delta[31:0];
    endfunction

    function automatic void clear_series();
        last_time = 0;
        last_value = 0;
        seen_first = 1'b0;
        area_acc = 0;
        pass_done = 1'b0;
    endfunction

    // works out the result, if any, that one accepted sample causes
    function automatic void predict_average(input in_word_t w);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] va;
        logic [31:0] vb;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] seg;
        logic [64:0] na;
        logic [63:0] q;
        out_word_t   r;
        logic        hit;
        r = '0;
        hit = 1'b0;
        if (pass_done)
        begin
            if (w.last_sample)
                clear_series();
            return;
        end
        if (win_start > win_end)
        begin
            r.status = ST_REVERSED;
            hit = 1'b1;
        end
        else if (!seen_first)
        begin
            if (w.sample_time > win_start)
            begin
                r.status = ST_EARLY;
                hit = 1'b1;
            end
            else if (w.sample_time == win_start && win_start == win_end)
            begin
                r.average = w.sample_value;
                hit = 1'b1;
            end
            else
            begin
                last_time = w.sample_time;
                last_value = w.sample_value;
                seen_first = 1'b1;
            end
        end
        else if (w.sample_time > last_time)
        begin
            if (win_start == win_end)
            begin
                if (w.sample_time >= win_start)
                begin
                    r.average = interp(last_time, last_value, w.sample_time,
                                       w.sample_value, win_start);
                    hit = 1'b1;
                end
            end
            else
            begin
                a = (last_time > win_start) ? last_time : win_start;
                b = (w.sample_time < win_end) ? w.sample_time : win_end;
                if (a < b)
                begin
                    va = interp(last_time, last_value, w.sample_time, w.sample_value, a);
                    vb = interp(last_time, last_value, w.sample_time, w.sample_value, b);
                    d = {32'd0, b - a};
                    s = {32'd0, va} + {32'd0, vb};
                    seg = d * (s >> 1) + ((d * s[0]) >> 1);
                    na = {1'b0, area_acc} + {1'b0, seg};
                    area_acc = na[64] ? 64'hFFFF_FFFF_FFFF_FFFF : na[63:0];
                end
                if (w.sample_time >= win_end)
                begin
                    q = area_acc / ({32'd0, win_end} - {32'd0, win_start});
                    r.average = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                last_time = w.sample_time;
                last_value = w.sample_value;
            end
        end
        if (!hit && w.last_sample)
        begin
            r.status = ST_LATE;
            hit = 1'b1;
        end
        if (hit)
        begin
            if (r.status != ST_OK)
                r.average = 0;
            averages_due = {averages_due, r};
            if (w.last_sample)
                clear_series();
            else
                pass_done = 1'b1;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (averages_due.size() == 0)
                report("result with nothing expected");
            else
            begin
                if (out_word.average !== averages_due[0].average)
                    report($sformatf("average %h want %h", out_word.average,
                                     averages_due[0].average));
                if (out_word.status !== averages_due[0].status)
                    report($sformatf("status %0d want %0d", out_word.status,
                                     averages_due[0].status));
                void'(averages_due.pop_front());
            end
        end
    end

    // receiver stall pattern
    int stall_mode;
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // lets everything drain, then sets the window
    task automatic set_window(input logic [31:0] s, input logic [31:0] e);
        in_valid <= 1'b0;
        while (averages_due.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        write_reg(REG_START, s);
        write_reg(REG_END, e);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        win_start = s;
        win_end = e;
    endtask

    int burst_left;

    task automatic send_sample(input logic [31:0] t, input logic [31:0] v,
                               input logic last);
        in_word_t w;
        w.sample_time = t;
        w.sample_value = v;
        w.last_sample = last;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_average(w);
    endtask

    task automatic test_directed();
        set_window(32'd100, 32'd200);
        send_sample(32'd50, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'd150, 32'd0, 1'b0);
        send_sample(32'd250, 32'h0001_0000, 1'b1);
        send_sample(32'd150, 32'd7, 1'b1);          // start before series
        send_sample(32'd0, 32'd7, 1'b0);
        send_sample(32'd0, 32'd9, 1'b0);            // repeated time ignored
        send_sample(32'd120, 32'd9, 1'b1);          // end after series
        set_window(32'd300, 32'd300);
        send_sample(32'd300, 32'h1234_5678, 1'b0);  // point window hit exactly
        send_sample(32'd400, 32'd1, 1'b0);          // finished, ignored
        send_sample(32'd500, 32'd1, 1'b1);
        send_sample(32'd10, 32'd0, 1'b0);
        send_sample(32'd1000, 32'hFFFF_FFFF, 1'b1); // interpolated point
        set_window(32'd0, 32'hFFFF_FFFF);
        send_sample(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        set_window(32'hFFFF_FFFF, 32'd0);            // reversed
        send_sample(32'd5, 32'd5, 1'b0);
        send_sample(32'd6, 32'd5, 1'b1);
        set_window(32'd0, 32'd1);
        send_sample(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'd1, 32'hFFFF_FFFE, 1'b1);
    endtask

    task automatic test_random();
        int n;
        int len;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] t;
        logic [31:0] step;
        n = 0;
        while (n < 1900)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: begin s = $urandom; e = $urandom; end
                    1: begin s = $urandom_range(0, 1000); e = s; end
                    2: begin s = 32'd0; e = 32'hFFFF_FFFF; end
                    default:
                    begin
                        s = $urandom_range(0, 100000);
                        e = s + $urandom_range(1, 100000);
                    end
                endcase
                set_window(s, e);
            end
            len = $urandom_range(2, 14);
            if (win_start > 32'd50000 && $urandom_range(0, 3) != 0)
                t = win_start - $urandom_range(0, 50000);
            else
                t = $urandom_range(0, 10) == 0 ? $urandom : win_start;
            if (win_start <= win_end && ($urandom_range(0, 3) == 0))
                t = $urandom_range(0, win_start < 100 ? win_start : 100);
            for (int i = 0; i < len; i++)
            begin
                send_sample(t, $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ?
                            32'hFFFF_FFFF : 32'd0) : $urandom,
                            (i == len - 1) || ($urandom_range(0, 40) == 0));
                n++;
                step = (win_end > win_start) ? (win_end - win_start) / 4 + 1 : 32'd500;
                case ($urandom_range(0, 9))
                    0: ;                                          // repeated time
                    1: t = t - $urandom_range(0, 10);
                    2: t = $urandom;
                    default: t = t + $urandom_range(1, step);
                endcase
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        errors = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        win_start = 0;
        win_end = 0;
        clear_series();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (averages_due.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && averages_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
